// ===== src/fir39_pkg.sv =====
package fir39_pkg;

    // Filter geometry
    localparam int TAPS        = 39;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int COEF_FRAC   = 15;
    localparam int COEF_COUNT  = 39;

    // Partial sums are exact: product width plus growth over all taps
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(TAPS + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    // Q1.15 low-pass coefficients, symmetric; zero beyond the table
    function automatic coef_t coef_at(input int idx);
        coef_t c;
        c = '0;
        case (idx)
            0, 38:   c = 16'sd32;
            1, 37:   c = 16'sd38;
            2, 36:   c = -16'sd34;
            3, 35:   c = -16'sd80;
            4, 34:   c = 16'sd38;
            5, 33:   c = 16'sd167;
            6, 32:   c = -16'sd15;
            7, 31:   c = -16'sd308;
            8, 30:   c = -16'sd76;
            9, 29:   c = 16'sd497;
            10, 28:  c = 16'sd285;
            11, 27:  c = -16'sd717;
            12, 26:  c = -16'sd687;
            13, 25:  c = 16'sd940;
            14, 24:  c = 16'sd1434;
            15, 23:  c = -16'sd1132;
            16, 22:  c = -16'sd3048;
            17, 21:  c = 16'sd1262;
            18, 20:  c = 16'sd10264;
            19:      c = 16'sd15045;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/fir_filter_39_tap.sv =====
// 39-tap low-pass FIR filter, Q1.15 in and out.
// Input channel s_axis: one sample per word. Output channel m_axis: one
// filtered sample per input word, in the same order.
// Built as a transposed chain of tap cells: each accepted sample is
// broadcast to every cell, which adds its product to the partial sum of
// its neighbour. The head tap completes the sum into the output register.
// The result appears on m_axis in the cycle after the sample is
// accepted. Throughput: one word per cycle while the receiver takes results,
// set by the single multiply and add in each cell.
// Rounding is half up, then saturation to the 16-bit sample range.
// Reset clears every partial sum, which equals an all-zero delay line,
// and empties the output register.
// When the receiver stalls, s_axis_tready stays high only while the output
// register is empty; otherwise the chain holds and accepts nothing.
module fir_filter_39_tap
    import fir39_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] sample_out
);

    sample_t sample;
    sample_t result;
    logic    accept;
    acc_t    sums [1:TAPS];

    assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign accept = s_axis_tvalid && s_axis_tready;

    // end of chain carries nothing in
    assign sums[TAPS] = '0;

    // tap cells, newest-sample side next to the head
    for (genvar k = 1; k < TAPS; k++)
    begin : g_cell
        fir39_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (accept),
            .sample  (sample),
            .coef    (coef_at(k)),
            .sum_in  (sums[k+1]),
            .sum_out (sums[k])
        );
    end

    fir39_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .sample    (sample),
        .coef      (coef_at(0)),
        .sum_in    (sums[1]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tdata = result;

    // every accepted word yields a result word next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    // input side is held only while an untaken result occupies the output
    a_ready_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // a result that is taken with no new word leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !s_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result repeated after being taken");

endmodule

// ===== src/fir39_cell.sv =====
module fir39_cell
    import fir39_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  sample_t sample,
    input  coef_t   coef,
    input  acc_t    sum_in,
    output acc_t    sum_out
);

    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;
    acc_t sum_reg;
    acc_t sum_next;

    // one tap: broadcast sample times coefficient, plus the neighbour's partial sum
    assign prod     = sample * coef;
    assign sum_next = ACC_W'(prod) + sum_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

// ===== src/fir39_out.sv =====
module fir39_out
    import fir39_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t sample,
    input  coef_t   coef,
    input  acc_t    sum_in,
    input  logic    out_ready,
    output logic    out_valid,
    output sample_t result
);

    localparam acc_t SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam acc_t SAT_LO = -SAT_HI - ACC_W'(1);
    localparam acc_t HALF   = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;
    acc_t acc_reg;
    acc_t acc_next;
    logic valid_reg;
    logic valid_next;
    logic accept;
    acc_t rounded;

    // head tap: finishes the sum for the newest sample
    assign prod     = sample * coef;
    assign acc_next = ACC_W'(prod) + sum_in;

    // output register frees as soon as its word is taken
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, drop the fraction, saturate
    assign rounded = (acc_reg + HALF) >>> COEF_FRAC;

    always_comb
    begin
        if (rounded > SAT_HI)
        begin
            result = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            result = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = rounded[SAMPLE_BITS-1:0];
        end
    end

    assign out_valid = valid_reg;

endmodule
